// ===== hdl/ptc_pkg.sv =====
// Shared types and constants for the prescaled timer/counter.
// No dependencies; used by every module of the block.
package ptc_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int FLAG_W = 4;
  localparam int MAX_CHANNELS = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int ACT_BITS = 3;

  // item actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // bus register selects
  localparam logic [1:0] REG_CTRL     = 2'd0;
  localparam logic [1:0] REG_MAIN     = 2'd1;
  localparam logic [1:0] REG_PRESCALE = 2'd2;
  localparam logic [1:0] REG_FLAGS    = 2'd3;

  // count modes
  localparam logic [1:0] MODE_TIMER = 2'd0;
  localparam logic [1:0] MODE_RISE  = 2'd1;
  localparam logic [1:0] MODE_FALL  = 2'd2;
  localparam logic [1:0] MODE_BOTH  = 2'd3;

  // per-channel action bits
  localparam int ACT_IRQ_BIT  = 0;
  localparam int ACT_RST_BIT  = 1;
  localparam int ACT_STOP_BIT = 2;

  // control register bits
  localparam int CTRL_RUN_BIT  = 0;
  localparam int CTRL_HOLD_BIT = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_MODE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIN_SELECT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_ACTIONS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_VALUE0   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_VALUE1   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_VALUE2   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_VALUE3   = 3'd7;

  // one result item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] count_value;
    logic [FLAG_W-1:0] match_flags;
    logic              irq;
    logic              running;
  } result_t;

endpackage

// ===== hdl/ptc_core.sv =====
// Timer state, configuration registers and the per-item update logic.
// Depends on ptc_pkg.
module ptc_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int MATCH_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [1:0]                       action,
  input  logic [1:0]                       reg_select,
  input  logic [ptc_pkg::DATA_W-1:0]       write_data,
  input  logic [1:0]                       pin_levels,
  input  logic                             cfg_we,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::DATA_W-1:0]       cfg_data,
  output ptc_pkg::result_t                 res
);

  localparam logic [ptc_pkg::FLAG_W-1:0] CHAN_MASK =
    ptc_pkg::FLAG_W'((1 << MATCH_CHANNELS) - 1);

  // configuration registers
  logic [ptc_pkg::DATA_W-1:0] prescale_limit;
  logic [1:0]                 count_mode;
  logic                       count_pin_select;
  logic [ptc_pkg::ACT_BITS*ptc_pkg::MAX_CHANNELS-1:0] match_actions;
  logic [ptc_pkg::DATA_W-1:0] match_value [ptc_pkg::MAX_CHANNELS];

  // timer state
  logic [COUNT_WIDTH-1:0]     main_count, main_count_next;
  logic [COUNT_WIDTH-1:0]     prescale_count, prescale_count_next;
  logic [ptc_pkg::FLAG_W-1:0] pending_flags, pending_flags_next;
  logic                       run_enable, run_enable_next;
  logic                       hold_reset, hold_reset_next;
  logic [1:0]                 previous_pins, previous_pins_next;

  logic [COUNT_WIDTH-1:0]     limit_c;
  logic [COUNT_WIDTH-1:0]     count_inc;
  logic [COUNT_WIDTH-1:0]     count_new;
  logic [ptc_pkg::MAX_CHANNELS-1:0] arm, hit, irq_en, stop_en;
  logic                       zero_next;
  logic                       pin_now, pin_before, rise, fall;
  logic                       edge_evt, count_evt;
  logic [ptc_pkg::DATA_W-1:0] rd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_limit   <= '0;
      count_mode       <= ptc_pkg::MODE_TIMER;
      count_pin_select <= 1'b0;
      match_actions    <= '0;
      for (int i = 0; i < ptc_pkg::MAX_CHANNELS; i++) begin
        match_value[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::CFG_PRESCALE_LIMIT: prescale_limit <= cfg_data;
        ptc_pkg::CFG_COUNT_MODE:     count_mode <= cfg_data[1:0];
        ptc_pkg::CFG_PIN_SELECT:     count_pin_select <= cfg_data[0];
        ptc_pkg::CFG_MATCH_ACTIONS:
          match_actions <= cfg_data[ptc_pkg::ACT_BITS*ptc_pkg::MAX_CHANNELS-1:0];
        ptc_pkg::CFG_MATCH_VALUE0:   match_value[0] <= cfg_data;
        ptc_pkg::CFG_MATCH_VALUE1:   match_value[1] <= cfg_data;
        ptc_pkg::CFG_MATCH_VALUE2:   match_value[2] <= cfg_data;
        ptc_pkg::CFG_MATCH_VALUE3:   match_value[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // match compare: reset arming on the old count, hits on the new count
  always_comb begin
    arm     = '0;
    hit     = '0;
    irq_en  = '0;
    stop_en = '0;
    limit_c = COUNT_WIDTH'(prescale_limit);
    count_inc = main_count + 1'b1;
    for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
      arm[ch] = match_actions[ptc_pkg::ACT_BITS*ch + ptc_pkg::ACT_RST_BIT] &&
                (COUNT_WIDTH'(match_value[ch]) == main_count);
      irq_en[ch]  = match_actions[ptc_pkg::ACT_BITS*ch + ptc_pkg::ACT_IRQ_BIT];
      stop_en[ch] = match_actions[ptc_pkg::ACT_BITS*ch + ptc_pkg::ACT_STOP_BIT];
    end
    zero_next = |arm;
    count_new = zero_next ? '0 : count_inc;
    for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
      hit[ch] = (COUNT_WIDTH'(match_value[ch]) == count_new);
    end
  end

  // pin edge detect on the selected count pin
  always_comb begin
    pin_now    = pin_levels[count_pin_select];
    pin_before = previous_pins[count_pin_select];
    rise       = pin_now && !pin_before;
    fall       = !pin_now && pin_before;
    case (count_mode)
      ptc_pkg::MODE_RISE: edge_evt = rise;
      ptc_pkg::MODE_FALL: edge_evt = fall;
      ptc_pkg::MODE_BOTH: edge_evt = rise || fall;
      default:            edge_evt = 1'b0;
    endcase
  end

  // next state and read data for one item
  always_comb begin
    main_count_next     = main_count;
    prescale_count_next = prescale_count;
    pending_flags_next  = pending_flags;
    run_enable_next     = run_enable;
    hold_reset_next     = hold_reset;
    previous_pins_next  = previous_pins;
    count_evt           = 1'b0;
    rd                  = '0;
    unique case (action)
      ptc_pkg::ACT_TICK: begin
        previous_pins_next = pin_levels;
        if (run_enable && !hold_reset) begin
          if (count_mode == ptc_pkg::MODE_TIMER) begin
            if (prescale_count == limit_c) begin
              prescale_count_next = '0;
              count_evt = 1'b1;
            end else begin
              prescale_count_next = prescale_count + 1'b1;
            end
          end else begin
            count_evt = edge_evt;
          end
        end
        if (count_evt) begin
          main_count_next = count_new;
          pending_flags_next = pending_flags |
                               ptc_pkg::FLAG_W'(hit & irq_en);
          if (|(hit & stop_en)) begin
            run_enable_next = 1'b0;
          end
        end
      end
      ptc_pkg::ACT_WRITE: begin
        unique case (reg_select)
          ptc_pkg::REG_CTRL: begin
            run_enable_next = write_data[ptc_pkg::CTRL_RUN_BIT];
            hold_reset_next = write_data[ptc_pkg::CTRL_HOLD_BIT];
            if (write_data[ptc_pkg::CTRL_HOLD_BIT]) begin
              main_count_next     = '0;
              prescale_count_next = '0;
            end
          end
          ptc_pkg::REG_MAIN: begin
            if (!hold_reset) main_count_next = COUNT_WIDTH'(write_data);
          end
          ptc_pkg::REG_PRESCALE: begin
            if (!hold_reset) prescale_count_next = COUNT_WIDTH'(write_data);
          end
          default: begin
            pending_flags_next = pending_flags &
                                 ~(write_data[ptc_pkg::FLAG_W-1:0] & CHAN_MASK);
          end
        endcase
      end
      ptc_pkg::ACT_READ: begin
        unique case (reg_select)
          ptc_pkg::REG_CTRL:
            rd = {{(ptc_pkg::DATA_W-2){1'b0}}, hold_reset, run_enable};
          ptc_pkg::REG_MAIN:     rd = ptc_pkg::DATA_W'(main_count);
          ptc_pkg::REG_PRESCALE: rd = ptc_pkg::DATA_W'(prescale_count);
          default: rd = {{(ptc_pkg::DATA_W-ptc_pkg::FLAG_W){1'b0}}, pending_flags};
        endcase
      end
      default: ;
    endcase
  end

  // state registers, updated on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      main_count     <= '0;
      prescale_count <= '0;
      pending_flags  <= '0;
      run_enable     <= 1'b0;
      hold_reset     <= 1'b0;
      previous_pins  <= '0;
    end else if (step) begin
      main_count     <= main_count_next;
      prescale_count <= prescale_count_next;
      pending_flags  <= pending_flags_next & CHAN_MASK;
      run_enable     <= run_enable_next;
      hold_reset     <= hold_reset_next;
      previous_pins  <= previous_pins_next;
    end
  end

  // result item seen after this transfer
  always_comb begin
    res.read_data   = rd;
    res.count_value = ptc_pkg::DATA_W'(main_count_next);
    res.match_flags = pending_flags_next & CHAN_MASK;
    res.irq         = |(pending_flags_next & CHAN_MASK);
    res.running     = run_enable_next && !hold_reset_next;
  end

endmodule

// ===== hdl/ptc_outreg.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on ptc_pkg for the result type.
module ptc_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ptc_pkg::result_t res_in,
  output logic             out_valid,
  input  logic             out_ready,
  output ptc_pkg::result_t res_out
);

  // free when empty or being drained this cycle
  assign in_ready = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== hdl/prescaled_timer_counter_with_match.sv =====
// Top level of the prescaled 32-bit timer/counter with match channels.
// Depends on ptc_pkg, ptc_core and ptc_outreg.
//
//   channel   signals                                       handshake
//   -------   --------------------------------------------  -----------------
//   input     action reg_select write_data pin_levels       in_valid/in_ready
//   output    read_data count_value match_flags irq running out_valid/out_ready
//   config    cfg_index cfg_data                            cfg_we, no wait
//
// One item per cycle while the output is not stalled: the timer state updates
// on the input transfer and the result lands in the output register with it.
// A stalled result blocks only when it is not drained that same cycle
// (in_ready = !out_valid || out_ready).
// Synchronous reset clears counters, flags, control and all config registers.
module prescaled_timer_counter_with_match #(
  parameter int COUNT_WIDTH = 32,
  parameter int MATCH_CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      action,
  input  logic [1:0]                      reg_select,
  input  logic [ptc_pkg::DATA_W-1:0]      write_data,
  input  logic [1:0]                      pin_levels,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptc_pkg::DATA_W-1:0]      read_data,
  output logic [ptc_pkg::DATA_W-1:0]      count_value,
  output logic [ptc_pkg::FLAG_W-1:0]      match_flags,
  output logic                            irq,
  output logic                            running,
  input  logic                            cfg_we,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptc_pkg::DATA_W-1:0]      cfg_data
);

  ptc_pkg::result_t res_core;
  ptc_pkg::result_t res_reg;

  // timer state and update logic
  ptc_core #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .MATCH_CHANNELS(MATCH_CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (in_valid && in_ready),
    .action     (action),
    .reg_select (reg_select),
    .write_data (write_data),
    .pin_levels (pin_levels),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res_core)
  );

  // result register
  ptc_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_core),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_reg)
  );

  assign read_data   = res_reg.read_data;
  assign count_value = res_reg.count_value;
  assign match_flags = res_reg.match_flags;
  assign irq         = res_reg.irq;
  assign running     = res_reg.running;

endmodule

// ===== hdl/ptc_checker.sv =====
// Port-level assertions for the prescaled timer/counter, bound to the top.
// Depends on ptc_pkg for field widths.
module ptc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ptc_pkg::DATA_W-1:0] count_value,
  input logic [ptc_pkg::FLAG_W-1:0] match_flags,
  input logic                       irq
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // empty result register must accept
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // an input transfer always yields a result next cycle
  a_transfer_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("input transfer produced no result");

  // interrupt line follows the flags
  a_irq_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq == (|match_flags)))
    else $error("irq does not match pending flags");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(count_value)))
    else $error("stalled result changed");

endmodule

bind prescaled_timer_counter_with_match ptc_checker u_ptc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .count_value (count_value),
  .match_flags (match_flags),
  .irq         (irq)
);
